// File: sv/shfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfe_pkg
// Shared types and constants for the signature hashed field extractor.
// ----------------------------------------------------------------------------
package shfe_pkg;

  // Input beat: one byte of the signature packet body
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // Result beat: one per packet, on its last byte
  typedef struct packed {
    logic        sig_ok;
    logic [7:0]  sig_version;
    logic [7:0]  sig_type;
    logic [31:0] creation_time;
    logic        issuer_found;
    logic [63:0] issuer_key_id;
  } out_beat_t;

  // Signature versions accepted
  localparam logic [7:0] SIG_V4 = 8'd4;
  localparam logic [7:0] SIG_V6 = 8'd6;

  // Hashed length field size per version, and the five-byte length form
  localparam logic [2:0] HLEN_V4_BYTES = 3'd2;
  localparam logic [2:0] HLEN_V6_BYTES = 3'd4;
  localparam logic [2:0] LEN5_BYTES    = 3'd4;

  // Subpacket length encoding
  localparam logic [7:0] LEN_TWO_BASE  = 8'd192;
  localparam logic [7:0] LEN_BAD_BASE  = 8'd224;
  localparam logic [7:0] LEN_FIVE_MARK = 8'd255;
  localparam logic [7:0] KIND_MASK     = 8'h7F;

  // Subpacket kinds of interest
  localparam logic [6:0] SUB_CREATED = 7'd2;
  localparam logic [6:0] SUB_ISSUER  = 7'd16;
  localparam logic [6:0] SUB_FPR     = 7'd33;

  // Value sizes and the fingerprint version that holds the key id up front
  localparam int unsigned VIDX_W = 5;
  localparam logic [VIDX_W-1:0] CREATED_BYTES = VIDX_W'(4);
  localparam logic [VIDX_W-1:0] ISSUER_BYTES  = VIDX_W'(8);
  localparam logic [VIDX_W-1:0] FPR_BYTES     = VIDX_W'(21);
  localparam logic [7:0]        FPR_V6        = 8'd6;

endpackage

// File: sv/shfe_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shfe_walker
// Per-byte header decode and hashed subpacket walk; builds the result beat.
// ----------------------------------------------------------------------------
module shfe_walker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               beat_valid,
  input  shfe_pkg::in_beat_t beat,
  output shfe_pkg::out_beat_t result
);
  import shfe_pkg::*;

  typedef enum logic [3:0] {
    PH_VERSION, PH_TYPE, PH_PKALG, PH_HASHALG, PH_HLEN,
    PH_SLEN0, PH_SLEN2, PH_SLEN5, PH_KIND, PH_VALUE, PH_TAIL, PH_BAD
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic [2:0]        fcount_r, fcount_nxt;
  logic [31:0]       hleft_r, hleft_nxt;
  logic [31:0]       accum_r, accum_nxt;
  logic [31:0]       subleft_r, subleft_nxt;
  logic [6:0]        kind_r, kind_nxt;
  logic [VIDX_W-1:0] vidx_r, vidx_nxt;
  logic [7:0]        fvb_r, fvb_nxt;
  logic [63:0]       window_r, window_nxt;
  logic [7:0]        ver_r, ver_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [31:0]       created_r, created_nxt;
  logic [63:0]       issuer_r, issuer_nxt;
  logic              iflag_r, iflag_nxt;
  logic              hbad_r, hbad_nxt;
  logic              stopped_r, stopped_nxt;

  logic [7:0]        b;
  logic [31:0]       hl_dec;
  logic [31:0]       acc_sh;
  logic [2:0]        fc_inc;
  logic [2:0]        hlen_bytes;
  logic              len_fire;
  logic [31:0]       len_val;
  logic [7:0]        fvb_eff;
  logic              take;
  logic [VIDX_W-1:0] vidx_inc;
  logic [31:0]       sub_dec;
  logic              complete;

  assign b          = beat.data_byte;
  assign hl_dec     = hleft_r - 32'd1;
  assign acc_sh     = {accum_r[23:0], b};
  assign fc_inc     = fcount_r + 3'd1;
  assign hlen_bytes = (ver_r == SIG_V6) ? HLEN_V6_BYTES : HLEN_V4_BYTES;
  assign fvb_eff    = (vidx_r == '0) ? b : fvb_r;
  assign vidx_inc   = (vidx_r == '1) ? vidx_r : vidx_r + 1'b1;
  assign sub_dec    = subleft_r - 32'd1;

  // Decide whether a value byte joins the window
  always_comb begin
    case (kind_r)
      SUB_CREATED: take = (vidx_r < CREATED_BYTES);
      SUB_ISSUER:  take = (vidx_r < ISSUER_BYTES);
      SUB_FPR:     take = (fvb_eff == FPR_V6) ?
                          ((vidx_r >= VIDX_W'(1)) && (vidx_r <= ISSUER_BYTES)) : 1'b1;
      default:     take = 1'b0;
    endcase
  end

  // Next state for one byte
  always_comb begin
    phase_nxt   = phase_r;
    fcount_nxt  = fcount_r;
    hleft_nxt   = hleft_r;
    accum_nxt   = accum_r;
    subleft_nxt = subleft_r;
    kind_nxt    = kind_r;
    vidx_nxt    = vidx_r;
    fvb_nxt     = fvb_r;
    window_nxt  = window_r;
    ver_nxt     = ver_r;
    type_nxt    = type_r;
    created_nxt = created_r;
    issuer_nxt  = issuer_r;
    iflag_nxt   = iflag_r;
    hbad_nxt    = hbad_r;
    stopped_nxt = stopped_r;
    len_fire    = 1'b0;
    len_val     = 32'd0;

    case (phase_r)
      PH_VERSION: begin
        ver_nxt = b;
        if (b == SIG_V4 || b == SIG_V6) begin
          phase_nxt = PH_TYPE;
        end else begin
          hbad_nxt  = 1'b1;
          phase_nxt = PH_BAD;
        end
      end
      PH_TYPE: begin
        type_nxt  = b;
        phase_nxt = PH_PKALG;
      end
      PH_PKALG: begin
        phase_nxt = PH_HASHALG;
      end
      PH_HASHALG: begin
        accum_nxt  = 32'd0;
        fcount_nxt = 3'd0;
        phase_nxt  = PH_HLEN;
      end
      PH_HLEN: begin
        accum_nxt  = acc_sh;
        fcount_nxt = fc_inc;
        if (fc_inc >= hlen_bytes) begin
          hleft_nxt = acc_sh;
          phase_nxt = (acc_sh == 32'd0) ? PH_TAIL : PH_SLEN0;
        end
      end
      PH_SLEN0, PH_SLEN2, PH_SLEN5, PH_KIND, PH_VALUE: begin
        hleft_nxt = hl_dec;
        if (!stopped_r) begin
          case (phase_r)
            PH_SLEN0: begin
              if (b < LEN_TWO_BASE) begin
                len_fire = 1'b1;
                len_val  = {24'd0, b};
              end else if (b < LEN_BAD_BASE) begin
                accum_nxt = {24'd0, b - LEN_TWO_BASE};
                phase_nxt = PH_SLEN2;
              end else if (b == LEN_FIVE_MARK) begin
                accum_nxt  = 32'd0;
                fcount_nxt = 3'd0;
                phase_nxt  = PH_SLEN5;
              end else begin
                stopped_nxt = 1'b1;
              end
            end
            PH_SLEN2: begin
              len_fire = 1'b1;
              len_val  = {19'd0, accum_r[4:0], b} + {24'd0, LEN_TWO_BASE};
            end
            PH_SLEN5: begin
              accum_nxt  = acc_sh;
              fcount_nxt = fc_inc;
              if (fc_inc >= LEN5_BYTES) begin
                len_fire = 1'b1;
                len_val  = acc_sh;
              end
            end
            PH_KIND: begin
              kind_nxt   = 7'(b & KIND_MASK);
              vidx_nxt   = '0;
              window_nxt = 64'd0;
              fvb_nxt    = 8'd0;
              phase_nxt  = (subleft_r == 32'd0) ? PH_SLEN0 : PH_VALUE;
            end
            default: begin
              if (vidx_r == '0) begin
                fvb_nxt = b;
              end
              if (take) begin
                window_nxt = {window_r[55:0], b};
              end
              vidx_nxt    = vidx_inc;
              subleft_nxt = sub_dec;
              // Subpacket done: keep its value when long enough
              if (sub_dec == 32'd0) begin
                if (kind_r == SUB_CREATED && vidx_inc >= CREATED_BYTES) begin
                  created_nxt = window_nxt[31:0];
                end else if ((kind_r == SUB_ISSUER && vidx_inc >= ISSUER_BYTES) ||
                             (kind_r == SUB_FPR && vidx_inc >= FPR_BYTES)) begin
                  issuer_nxt = window_nxt;
                  iflag_nxt  = 1'b1;
                end
                phase_nxt = PH_SLEN0;
              end
            end
          endcase
          // Check a finished length against what is left of the hashed area
          if (len_fire) begin
            if (len_val == 32'd0 || len_val > hl_dec) begin
              stopped_nxt = 1'b1;
            end else begin
              subleft_nxt = len_val - 32'd1;
              phase_nxt   = PH_KIND;
            end
          end
        end
        if (hl_dec == 32'd0) begin
          phase_nxt = PH_TAIL;
        end
      end
      default: begin
      end
    endcase
  end

  // Build the result from the state after this byte
  always_comb begin
    complete              = (phase_nxt == PH_TAIL) && !hbad_nxt;
    result.sig_ok         = complete && (created_nxt != 32'd0);
    result.sig_version    = ver_nxt;
    result.sig_type       = type_nxt;
    result.creation_time  = complete ? created_nxt : 32'd0;
    result.issuer_found   = complete && iflag_nxt;
    result.issuer_key_id  = complete ? issuer_nxt : 64'd0;
  end

  // Hold walk state; clear it after the last byte of a packet
  always_ff @(posedge clk) begin
    if (!rst_n || (beat_valid && beat.last_byte)) begin
      phase_r   <= PH_VERSION;
      fcount_r  <= 3'd0;
      hleft_r   <= 32'd0;
      accum_r   <= 32'd0;
      subleft_r <= 32'd0;
      kind_r    <= 7'd0;
      vidx_r    <= '0;
      fvb_r     <= 8'd0;
      window_r  <= 64'd0;
      ver_r     <= 8'd0;
      type_r    <= 8'd0;
      created_r <= 32'd0;
      issuer_r  <= 64'd0;
      iflag_r   <= 1'b0;
      hbad_r    <= 1'b0;
      stopped_r <= 1'b0;
    end else if (beat_valid) begin
      phase_r   <= phase_nxt;
      fcount_r  <= fcount_nxt;
      hleft_r   <= hleft_nxt;
      accum_r   <= accum_nxt;
      subleft_r <= subleft_nxt;
      kind_r    <= kind_nxt;
      vidx_r    <= vidx_nxt;
      fvb_r     <= fvb_nxt;
      window_r  <= window_nxt;
      ver_r     <= ver_nxt;
      type_r    <= type_nxt;
      created_r <= created_nxt;
      issuer_r  <= issuer_nxt;
      iflag_r   <= iflag_nxt;
      hbad_r    <= hbad_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: sv/signature_hashed_field_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_hashed_field_extractor
// Reads a signature packet body byte by byte and reports its hashed fields.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_beat) carries one body byte per
//   beat; last_byte marks the final byte of a packet. Result channel
//   (out_valid / out_stall / out_beat) gives one beat per packet with the
//   version, type, creation time and issuer key id.
//   Throughput: one byte per cycle while in_stall is low. Each byte passes an input register, then
//   the per-byte walk logic, then the result register.
//   Non-last bytes keep flowing while a result is held; in_stall rises only
//   when a last byte reaches the walker while the previous result is still
//   held by out_stall.
//   Reset clears the walk state and empties both registers; the walk state
//   also clears itself after every last byte, ready for the next packet.
// ----------------------------------------------------------------------------
module signature_hashed_field_extractor (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shfe_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output shfe_pkg::out_beat_t out_beat
);
  import shfe_pkg::*;

  logic      in_valid_r;
  in_beat_t  in_beat_r;
  logic      out_valid_r;
  out_beat_t out_beat_r;
  out_beat_t result;
  logic      walk_go;
  logic      emit;

  // Hold the input beat only when its result has nowhere to go
  assign in_stall = in_valid_r && in_beat_r.last_byte && out_valid_r && out_stall;
  assign walk_go  = in_valid_r && !in_stall;
  assign emit     = walk_go && in_beat_r.last_byte;

  shfe_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (walk_go),
    .beat       (in_beat_r),
    .result     (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_beat_r <= in_beat;
    end
  end

  // Result register: load on a last byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (emit) begin
      out_beat_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Stall only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A last byte through the walker yields a result next cycle
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_go && in_beat_r.last_byte) |=> out_valid)
    else $error("last byte gave no result");

  // A good signature has a known version and a creation time
  a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.sig_ok) |->
      ((out_beat.creation_time != 32'd0) &&
       (out_beat.sig_version == SIG_V4 || out_beat.sig_version == SIG_V6)))
    else $error("sig_ok with bad version or zero creation time");

endmodule

// File: sim/signature_hashed_field_extractor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_hashed_field_extractor_test
// Feeds signature packet bodies byte by byte into the extractor, with random
// gaps on the input and random stalls on the result side. A byte-level walker
// of the hashed area predicts one result per packet; each result beat is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module signature_hashed_field_extractor_test;
  import shfe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1100;
  localparam int MIN_PACKETS  = 40;

  typedef enum logic [3:0] {
    P_VERSION, P_TYPE, P_PKALG, P_HASHALG, P_HLEN,
    P_SLEN0, P_SLEN2, P_SLEN5, P_KIND, P_VALUE, P_TAIL, P_BAD
  } walk_phase_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int        cycle_count = 0;
  int        error_count = 0;
  logic      quiet_stretch;

  in_beat_t  pending_beats[$];
  out_beat_t expected_results[$];
  out_beat_t oldest_result;

  // Packet under construction
  logic [7:0] body[$];
  logic [7:0] area[$];
  int         queued_bytes = 0;
  int         queued_packets = 0;

  // Walker state
  walk_phase_e phase;
  logic [3:0]  byte_cnt;
  logic [31:0] hashed_left;
  logic [31:0] len_acc;
  logic [31:0] sub_left;
  logic [6:0]  cur_kind;
  logic [31:0] value_idx;
  logic [7:0]  first_val;
  logic [63:0] value_win;
  logic [7:0]  version_seen;
  logic [7:0]  type_seen;
  logic [31:0] created;
  logic [63:0] issuer;
  logic        issuer_seen;
  logic        hdr_bad;
  logic        walk_halted;

  signature_hashed_field_extractor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  // Clock and the single reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // No idling on either side in this window
  assign quiet_stretch = (cycle_count >= 500) && (cycle_count < 800);

  // --------------------------------------------------------------------------
  // Walker of the packet body
  // --------------------------------------------------------------------------
  task automatic clear_walk();
    phase        = P_VERSION;
    byte_cnt     = '0;
    hashed_left  = '0;
    len_acc      = '0;
    sub_left     = '0;
    cur_kind     = '0;
    value_idx    = '0;
    first_val    = '0;
    value_win    = '0;
    version_seen = '0;
    type_seen    = '0;
    created      = '0;
    issuer       = '0;
    issuer_seen  = 1'b0;
    hdr_bad      = 1'b0;
    walk_halted  = 1'b0;
  endtask

  // Keep the value of a finished subpacket if it is long enough
  task automatic close_subpacket();
    if (cur_kind == SUB_CREATED && value_idx >= 32'(CREATED_BYTES)) begin
      created = value_win[31:0];
    end else if (cur_kind == SUB_ISSUER && value_idx >= 32'(ISSUER_BYTES)) begin
      issuer      = value_win;
      issuer_seen = 1'b1;
    end else if (cur_kind == SUB_FPR && value_idx >= 32'(FPR_BYTES)) begin
      issuer      = value_win;
      issuer_seen = 1'b1;
    end
    phase = P_SLEN0;
  endtask

  task automatic length_decoded(input logic [31:0] len);
    if (len == 0 || len > hashed_left) begin
      walk_halted = 1'b1;
    end else begin
      sub_left = len - 1;
      phase    = P_KIND;
    end
  endtask

  task automatic value_in(input logic [7:0] b);
    logic        keep;
    logic [31:0] i;
    i = value_idx;
    if (i == 0) first_val = b;
    case (cur_kind)
      SUB_CREATED: keep = i < 32'(CREATED_BYTES);
      SUB_ISSUER:  keep = i < 32'(ISSUER_BYTES);
      SUB_FPR:     keep = (first_val == FPR_V6) ? (i >= 1 && i <= 32'(ISSUER_BYTES)) : 1'b1;
      default:     keep = 1'b0;
    endcase
    if (keep) value_win = {value_win[55:0], b};
    value_idx = i + 1;
    sub_left  = sub_left - 1;
    if (sub_left == 0) close_subpacket();
  endtask

  task automatic hashed_in(input logic [7:0] b);
    hashed_left = hashed_left - 1;
    if (!walk_halted) begin
      case (phase)
        P_SLEN0: begin
          if (b < LEN_TWO_BASE) begin
            length_decoded({24'd0, b});
          end else if (b < LEN_BAD_BASE) begin
            len_acc = {24'd0, b - LEN_TWO_BASE};
            phase   = P_SLEN2;
          end else if (b == LEN_FIVE_MARK) begin
            len_acc  = '0;
            byte_cnt = '0;
            phase    = P_SLEN5;
          end else begin
            walk_halted = 1'b1;
          end
        end
        P_SLEN2: begin
          length_decoded((len_acc << 8) + {24'd0, b} + {24'd0, LEN_TWO_BASE});
        end
        P_SLEN5: begin
          len_acc  = (len_acc << 8) | {24'd0, b};
          byte_cnt = byte_cnt + 1;
          if (byte_cnt >= 4'(LEN5_BYTES)) length_decoded(len_acc);
        end
        P_KIND: begin
          cur_kind  = b[6:0] & KIND_MASK[6:0];
          value_idx = '0;
          value_win = '0;
          first_val = '0;
          if (sub_left == 0) close_subpacket();
          else phase = P_VALUE;
        end
        default: begin
          value_in(b);
        end
      endcase
    end
    if (hashed_left == 0) phase = P_TAIL;
  endtask

  task automatic header_in(input logic [7:0] b);
    case (phase)
      P_VERSION: begin
        version_seen = b;
        if (b == SIG_V4 || b == SIG_V6) begin
          phase = P_TYPE;
        end else begin
          hdr_bad = 1'b1;
          phase   = P_BAD;
        end
      end
      P_TYPE: begin
        type_seen = b;
        phase     = P_PKALG;
      end
      P_PKALG: phase = P_HASHALG;
      P_HASHALG: begin
        len_acc  = '0;
        byte_cnt = '0;
        phase    = P_HLEN;
      end
      P_HLEN: begin
        len_acc  = (len_acc << 8) | {24'd0, b};
        byte_cnt = byte_cnt + 1;
        if (byte_cnt >= ((version_seen == SIG_V6) ? 4'(HLEN_V6_BYTES) : 4'(HLEN_V4_BYTES)))
        begin
          hashed_left = len_acc;
          phase       = (hashed_left == 0) ? P_TAIL : P_SLEN0;
        end
      end
      P_SLEN0, P_SLEN2, P_SLEN5, P_KIND, P_VALUE: hashed_in(b);
      default: ;
    endcase
  endtask

  // Advance the walker by one accepted beat; a last byte yields a result
  task automatic predict_beat(input in_beat_t beat);
    out_beat_t res;
    logic      complete;
    header_in(beat.data_byte);
    if (beat.last_byte) begin
      complete          = (phase == P_TAIL) && !hdr_bad;
      res.sig_ok        = complete && (created != 0);
      res.sig_version   = version_seen;
      res.sig_type      = type_seen;
      res.creation_time = complete ? created : '0;
      res.issuer_found  = complete ? issuer_seen : 1'b0;
      res.issuer_key_id = complete ? issuer : '0;
      expected_results.push_back(res);
      clear_walk();
    end
  endtask

  // --------------------------------------------------------------------------
  // Packet builder
  // --------------------------------------------------------------------------
  task automatic put_length(input int unsigned len);
    int unsigned form;
    form = $urandom_range(9);
    if (len >= 192 && len <= 8383 && form < 7) begin
      area.push_back(8'(192 + ((len - 192) >> 8)));
      area.push_back(8'((len - 192) & 255));
    end else if (len < 192 && form < 8) begin
      area.push_back(8'(len));
    end else begin
      area.push_back(LEN_FIVE_MARK);
      area.push_back(8'(len >> 24));
      area.push_back(8'(len >> 16));
      area.push_back(8'(len >> 8));
      area.push_back(8'(len));
    end
  endtask

  task automatic put_subpacket();
    int unsigned pick;
    int unsigned vlen;
    logic [6:0]  kind;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 30) begin
      kind = SUB_CREATED;
      vlen = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : 4;
    end else if (pick < 50) begin
      kind = SUB_ISSUER;
      vlen = ($urandom_range(3) == 0) ? $urandom_range(4, 12) : 8;
    end else if (pick < 70) begin
      kind = SUB_FPR;
      case ($urandom_range(3))
        0: vlen = 21;
        1: vlen = 33;
        default: vlen = $urandom_range(15, 25);
      endcase
    end else begin
      kind = 7'($urandom_range(127));
      vlen = $urandom_range(0, 10);
    end
    // Rarely stretch the value to need the two-byte length form
    if ($urandom_range(49) == 0) vlen = $urandom_range(191, 210);
    put_length(vlen + 1);
    area.push_back({1'($urandom_range(1)), kind});
    for (int i = 0; i < vlen; i++) begin
      b = 8'($urandom_range(255));
      if (kind == SUB_FPR && i == 0 && $urandom_range(1) == 0) b = FPR_V6;
      if (kind == SUB_CREATED && i < 4 && pick < 3) b = 8'd0;
      area.push_back(b);
    end
  endtask

  task automatic put_malformed();
    case ($urandom_range(3))
      0: area.push_back(8'($urandom_range(224, 254)));
      1: area.push_back(8'd0);
      2: begin
        area.push_back(LEN_FIVE_MARK);
        repeat (4) area.push_back(8'd0);
      end
      default: begin
        area.push_back(LEN_FIVE_MARK);
        repeat (4) area.push_back(8'hFF);
      end
    endcase
  endtask

  // Queue the body as beats, last flag on the final byte
  task automatic queue_body();
    in_beat_t beat;
    for (int i = 0; i < body.size(); i++) begin
      beat.data_byte = body[i];
      beat.last_byte = (i == body.size() - 1);
      pending_beats.push_back(beat);
    end
    queued_bytes   += body.size();
    queued_packets += 1;
    body.delete();
  endtask

  task automatic build_packet();
    logic [7:0]  version;
    logic [31:0] hlen;
    int unsigned subs;
    int unsigned bad_at;
    int unsigned cut;
    area.delete();
    body.delete();
    if ($urandom_range(99) < 6) begin
      // Bad version, then bytes that must be ignored
      do version = 8'($urandom_range(255)); while (version == SIG_V4 || version == SIG_V6);
      body.push_back(version);
      repeat ($urandom_range(0, 6)) body.push_back(8'($urandom_range(255)));
    end else begin
      version = ($urandom_range(1) == 0) ? SIG_V4 : SIG_V6;
      body.push_back(version);
      repeat (3) body.push_back(8'($urandom_range(255)));
      subs   = $urandom_range(0, 4);
      bad_at = ($urandom_range(99) < 12) ? $urandom_range(0, subs) : subs + 1;
      for (int s = 0; s <= subs; s++) begin
        if (s == bad_at) put_malformed();
        if (s < subs) put_subpacket();
      end
      hlen = area.size();
      case ($urandom_range(19))
        0, 1: hlen = hlen + $urandom_range(1, 6);
        2, 3: hlen = (hlen > 4) ? hlen - $urandom_range(1, 4) : 0;
        4:    hlen = '1;
        default: ;
      endcase
      if (version == SIG_V6) begin
        body.push_back(hlen[31:24]);
        body.push_back(hlen[23:16]);
      end else if (hlen > 32'hFFFF) begin
        hlen = 32'hFFFF;
      end
      body.push_back(hlen[15:8]);
      body.push_back(hlen[7:0]);
      foreach (area[i]) body.push_back(area[i]);
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(255)));
      // Cut the body short now and then
      if ($urandom_range(99) < 8) begin
        cut = $urandom_range(1, body.size());
        while (body.size() > cut) void'(body.pop_back());
      end
    end
    queue_body();
  endtask

  // --------------------------------------------------------------------------
  // Input driver: hold a stalled beat, idle at random otherwise
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_beat);
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() != 0 && (quiet_stretch || $urandom_range(99) >= 24)) begin
          in_valid <= 1'b1;
          in_beat  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted beat with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_beat);
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("sig_ok", 64'(oldest_result.sig_ok), 64'(out_beat.sig_ok));
          check_field("sig_version", 64'(oldest_result.sig_version),
                      64'(out_beat.sig_version));
          check_field("sig_type", 64'(oldest_result.sig_type), 64'(out_beat.sig_type));
          check_field("creation_time", 64'(oldest_result.creation_time),
                      64'(out_beat.creation_time));
          check_field("issuer_found", 64'(oldest_result.issuer_found),
                      64'(out_beat.issuer_found));
          check_field("issuer_key_id", oldest_result.issuer_key_id,
                      out_beat.issuer_key_id);
        end
      end
      out_stall <= quiet_stretch ? 1'b0 : ($urandom_range(99) < 24);
    end
  end

  // Stop a run that hangs
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    clear_walk();

    // Bad version alone
    body.push_back(8'hFF);
    queue_body();
    // Version 4 with one creation time, nothing else
    body = '{SIG_V4, 8'h13, 8'h01, 8'h08, 8'h00, 8'h06, 8'h05, 8'h82,
             8'h00, 8'h00, 8'h00, 8'h01};
    queue_body();
    // Version 6 with an empty hashed area
    body = '{SIG_V6, 8'hFF, 8'h16, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_body();

    queued_bytes   = 0;
    queued_packets = 0;
    while (queued_bytes < RANDOM_BYTES || queued_packets < MIN_PACKETS) build_packet();

    // Drain, then let the pipeline settle
    @(posedge rst_n);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
